>>> rtl/pip_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_pkg
// Shared types and constants for the point-in-polygon classifier.
// ----------------------------------------------------------------------------
package pip_pkg;

	localparam int COORD_W  = 31;
	localparam int DIFF_W   = COORD_W + 1;
	localparam int PROD_W   = 2 * DIFF_W;
	localparam int SLOT_W   = 6;
	localparam int SLOTS    = 2 ** SLOT_W;
	localparam int CNT_W    = 7;
	localparam int MIN_POLY = 3;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	localparam logic [1:0] LOC_OUTSIDE  = 2'd0;
	localparam logic [1:0] LOC_INSIDE   = 2'd1;
	localparam logic [1:0] LOC_BOUNDARY = 2'd2;

	typedef logic signed [COORD_W-1:0] coord_t;

	// query token handed from cell to cell
	typedef struct packed {
		logic   valid;
		coord_t px;
		coord_t py;
		logic   parity;
		logic   on_edge;
	} pip_tok_t;

endpackage

>>> rtl/pip_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_cell
// One edge cell: holds one vertex, forms the edge to the next vertex and
// updates the crossing parity and boundary flag of the passing query.
// ----------------------------------------------------------------------------
module pip_cell
	import pip_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     adv,
	input  logic     active,
	input  logic     wr_en,
	input  coord_t   wr_x,
	input  coord_t   wr_y,
	input  coord_t   next_x,
	input  coord_t   next_y,
	output coord_t   vert_x,
	output coord_t   vert_y,
	input  pip_tok_t tok_in,
	output pip_tok_t tok_out
);

	coord_t vx_q, vy_q;

	logic signed [DIFF_W-1:0] dix, diy, djx, djy;
	logic signed [PROD_W-1:0] p_d, q_d;
	logic                     up_d, dn_d, box_d;

	pip_tok_t                 tok_s1;
	logic signed [PROD_W-1:0] p_s1, q_s1;
	logic                     up_s1, dn_s1, box_s1;

	pip_tok_t                 tok_s2;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			vx_q <= wr_x;
			vy_q <= wr_y;
		end
	end

	assign vert_x = vx_q;
	assign vert_y = vy_q;

	// (i - p) x (j - p)
	assign dix = {vx_q[COORD_W-1], vx_q} - {tok_in.px[COORD_W-1], tok_in.px};
	assign diy = {vy_q[COORD_W-1], vy_q} - {tok_in.py[COORD_W-1], tok_in.py};
	assign djx = {next_x[COORD_W-1], next_x} - {tok_in.px[COORD_W-1], tok_in.px};
	assign djy = {next_y[COORD_W-1], next_y} - {tok_in.py[COORD_W-1], tok_in.py};
	assign p_d = dix * djy;
	assign q_d = diy * djx;

	assign up_d  = active && (vx_q <= tok_in.px) && (tok_in.px < next_x);
	assign dn_d  = active && (next_x <= tok_in.px) && (tok_in.px < vx_q);
	assign box_d = active
		&& ((vx_q <= tok_in.px) || (next_x <= tok_in.px))
		&& ((tok_in.px <= vx_q) || (tok_in.px <= next_x))
		&& ((vy_q <= tok_in.py) || (next_y <= tok_in.py))
		&& ((tok_in.py <= vy_q) || (tok_in.py <= next_y));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1.valid <= 1'b0;
		end else if (adv) begin
			tok_s1 <= tok_in;
			p_s1   <= p_d;
			q_s1   <= q_d;
			up_s1  <= up_d;
			dn_s1  <= dn_d;
			box_s1 <= box_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s2.valid <= 1'b0;
		end else if (adv) begin
			tok_s2.valid   <= tok_s1.valid;
			tok_s2.px      <= tok_s1.px;
			tok_s2.py      <= tok_s1.py;
			tok_s2.parity  <= tok_s1.parity
				^ (up_s1 && (p_s1 < q_s1))
				^ (dn_s1 && (p_s1 > q_s1));
			tok_s2.on_edge <= tok_s1.on_edge || (box_s1 && (p_s1 == q_s1));
		end
	end

	assign tok_out = tok_s2;

endmodule

>>> rtl/point_in_polygon_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_polygon_test
// Ray-casting point-in-polygon classifier built as a chain of edge cells.
// ----------------------------------------------------------------------------
// A query (func = 1) raises out_valid once it has passed every edge cell and
// the output register. The first cell's two cross-product multiplies run in
// the transfer cycle itself. Each edge cell then holds the query in a register
// after the multiplies and in another after the compare. The output register
// takes the last compare. Queries enter one per cycle while the chain is not
// stalled and stream through the cells back to back. The whole chain stalls,
// and in_ready drops, while a result waits in the output register. A vertex
// write (func = 0) gives no result and is taken only once no query is left in
// the chain, so a write right after queries waits for them to drain. Vertex
// slots come up unwritten; there is no clearing pass.
// ----------------------------------------------------------------------------
module point_in_polygon_test
	import pip_pkg::*;
#(
	parameter int MAX_VERTICES = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CNT_W-1:0]          cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      func,
	input  logic [SLOT_W-1:0]         vertex_index,
	input  logic signed [COORD_W-1:0] point_x,
	input  logic signed [COORD_W-1:0] point_y,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [1:0]                location
);

	localparam int CELLS  = (MAX_VERTICES > SLOTS) ? SLOTS : MAX_VERTICES;
	localparam int IF_MAX = 2 * CELLS;
	localparam int IF_W   = $clog2(IF_MAX + 1);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] n_eff;
	logic             adv;
	logic             acc;
	logic             acc_wr;
	logic             acc_qry;
	logic             leave;
	logic [IF_W-1:0]  inflight_q;
	logic             out_valid_q;
	logic [1:0]       location_q;
	logic [1:0]       class_d;

	pip_tok_t tok [CELLS+1];
	coord_t   vx [CELLS];
	coord_t   vy [CELLS];
	coord_t   jx [CELLS];
	coord_t   jy [CELLS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_we) begin
			count_q <= cfg_data;
		end
	end

	assign n_eff = (count_q > CNT_W'(CELLS)) ? CNT_W'(CELLS) : count_q;

	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv && !((func == FUNC_WRITE) && (inflight_q != '0));
	assign acc      = in_valid && in_ready;
	assign acc_wr   = acc && (func == FUNC_WRITE);
	assign acc_qry  = acc && (func == FUNC_QUERY);
	assign leave    = adv && tok[CELLS].valid;

	always_comb begin
		tok[0].valid   = acc_qry;
		tok[0].px      = point_x;
		tok[0].py      = point_y;
		tok[0].parity  = 1'b0;
		tok[0].on_edge = 1'b0;
	end

	for (genvar k = 0; k < CELLS; k++) begin : g_cell
		if (k == CELLS - 1) begin : g_wrap
			assign jx[k] = vx[0];
			assign jy[k] = vy[0];
		end else begin : g_next
			assign jx[k] = (n_eff == CNT_W'(k + 1)) ? vx[0] : vx[k+1];
			assign jy[k] = (n_eff == CNT_W'(k + 1)) ? vy[0] : vy[k+1];
		end

		pip_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.active  (n_eff > CNT_W'(k)),
			.wr_en   (acc_wr && (vertex_index == SLOT_W'(k))),
			.wr_x    (point_x),
			.wr_y    (point_y),
			.next_x  (jx[k]),
			.next_y  (jy[k]),
			.vert_x  (vx[k]),
			.vert_y  (vy[k]),
			.tok_in  (tok[k]),
			.tok_out (tok[k+1])
		);
	end

	// queries in the chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			case ({acc_qry, leave})
				2'b10:   inflight_q <= inflight_q + IF_W'(1);
				2'b01:   inflight_q <= inflight_q - IF_W'(1);
				default: inflight_q <= inflight_q;
			endcase
		end
	end

	always_comb begin
		if (n_eff < CNT_W'(MIN_POLY)) begin
			class_d = LOC_OUTSIDE;
		end else if (tok[CELLS].on_edge) begin
			class_d = LOC_BOUNDARY;
		end else if (tok[CELLS].parity) begin
			class_d = LOC_INSIDE;
		end else begin
			class_d = LOC_OUTSIDE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= tok[CELLS].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			location_q <= class_d;
		end
	end

	assign out_valid = out_valid_q;
	assign location  = location_q;

`ifndef SYNTHESIS
	a_inflight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= IF_W'(IF_MAX))
		else $error("in-flight query count above chain depth");

	a_empty_chain: assert property (@(posedge clk) disable iff (!arst_n)
		(inflight_q == '0) |-> !tok[CELLS].valid)
		else $error("token leaves an empty chain");

	a_query_counted: assert property (@(posedge clk) disable iff (!arst_n)
		acc_qry |=> (inflight_q != '0))
		else $error("accepted query not counted in flight");

	a_write_drained: assert property (@(posedge clk) disable iff (!arst_n)
		acc_wr |-> !tok[CELLS].valid)
		else $error("vertex write while queries in flight");
`endif

endmodule

>>> tb/pip_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_checker
// Watches the vertex/query channel and the config port of the point-in-polygon
// classifier. It keeps its own copy of the polygon and the vertex count,
// predicts a location for every accepted query, and compares each result
// transfer with the oldest prediction. Mismatches and stray results are
// counted and reported.
// ----------------------------------------------------------------------------
module pip_checker
	import pip_pkg::*;
#(
	parameter int MAX_VERTICES = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CNT_W-1:0]  cfg_data,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic              func,
	input  logic [SLOT_W-1:0] vertex_index,
	input  coord_t            point_x,
	input  coord_t            point_y,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [1:0]        location,
	output int                failures,
	output int                outstanding
);

	coord_t           poly_x [MAX_VERTICES];
	coord_t           poly_y [MAX_VERTICES];
	logic [CNT_W-1:0] poly_size;
	logic [1:0]       expected_locations [$];
	logic [1:0]       oldest;

	// sign of (b - a) x (c - a), exact in 64 bits
	function automatic int turn_sign(input longint ax, ay, bx, by, cx, cy);
		longint p, q;
		p = (bx - ax) * (cy - ay);
		q = (by - ay) * (cx - ax);
		return (p > q) ? 1 : ((p < q) ? -1 : 0);
	endfunction

	function automatic logic [1:0] locate_point(input coord_t px, input coord_t py);
		int     n, j;
		logic   odd;
		longint x, y, ix, iy, jx, jy;
		n = (poly_size > MAX_VERTICES) ? MAX_VERTICES : int'(poly_size);
		if (n < MIN_POLY)
			return LOC_OUTSIDE;
		x = px;
		y = py;
		odd = 1'b0;
		for (int i = 0; i < n; i++) begin
			j = (i + 1 == n) ? 0 : i + 1;
			ix = poly_x[i];
			iy = poly_y[i];
			jx = poly_x[j];
			jy = poly_y[j];
			// half-open crossing rule
			if (ix <= x && x < jx && turn_sign(x, y, ix, iy, jx, jy) < 0)
				odd = ~odd;
			else if (jx <= x && x < ix && turn_sign(x, y, jx, jy, ix, iy) < 0)
				odd = ~odd;
			if (((ix < jx) ? ix : jx) <= x && x <= ((ix > jx) ? ix : jx) &&
			    ((iy < jy) ? iy : jy) <= y && y <= ((iy > jy) ? iy : jy) &&
			    turn_sign(x, y, ix, iy, jx, jy) == 0)
				return LOC_BOUNDARY;
		end
		return odd ? LOC_INSIDE : LOC_OUTSIDE;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_size = '0;
			failures = 0;
			outstanding = 0;
			expected_locations.delete();
		end else begin
			if (cfg_we)
				poly_size = cfg_data;
			if (in_valid && in_ready) begin
				if (func == FUNC_WRITE) begin
					if (vertex_index < MAX_VERTICES) begin
						poly_x[vertex_index] = point_x;
						poly_y[vertex_index] = point_y;
					end
				end else begin
					expected_locations.insert(expected_locations.size(),
						locate_point(point_x, point_y));
				end
			end
			if (out_valid && out_ready) begin
				if (expected_locations.size() == 0) begin
					$display("%0t: location %0d transferred with no query pending",
						$time, location);
					failures++;
				end else begin
					oldest = expected_locations.pop_front();
					if (location !== oldest) begin
						$display("%0t: location mismatch, expected %0d, actual %0d",
							$time, oldest, location);
						failures++;
					end
				end
			end
			outstanding = expected_locations.size();
		end
	end

endmodule

>>> tb/point_in_polygon_test_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_polygon_test_test
// Stimulus and verdict for the point-in-polygon classifier. A short directed
// pass covers degenerate polygons, extreme coordinates and edge/vertex hits;
// random phases then load polygons of varied size and scale and stream
// queries biased toward edges, vertices and vertex heights, with random gaps
// on both channels and one long output stall. Checking is in pip_checker.
// ----------------------------------------------------------------------------
module point_in_polygon_test_test;
	import pip_pkg::*;

	localparam int     MAX_VERTICES = 64;
	localparam int     DRAIN_CYCLES = 2 * MAX_VERTICES + 16;
	localparam int     CYCLE_LIMIT  = 1000000;
	localparam int     ITEM_TARGET  = 950;
	localparam coord_t COORD_MIN    = -(2 ** 30);
	localparam coord_t COORD_MAX    = 2 ** 30 - 1;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [CNT_W-1:0]  cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              func = FUNC_WRITE;
	logic [SLOT_W-1:0] vertex_index = '0;
	coord_t            point_x = '0;
	coord_t            point_y = '0;
	logic              out_ready = 1'b0;
	logic              in_ready;
	logic              out_valid;
	logic [1:0]        location;

	int     failures;
	int     outstanding;
	int     cycle_count = 0;
	int     items_sent = 0;
	bit     steady = 1'b0;
	bit     stall_sink = 1'b0;
	coord_t poly_x [MAX_VERTICES];
	coord_t poly_y [MAX_VERTICES];
	int     poly_m = 0;

	point_in_polygon_test #(.MAX_VERTICES(MAX_VERTICES)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.vertex_index (vertex_index),
		.point_x      (point_x),
		.point_y      (point_y),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.location     (location)
	);

	pip_checker #(.MAX_VERTICES(MAX_VERTICES)) location_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.vertex_index (vertex_index),
		.point_x      (point_x),
		.point_y      (point_y),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.location     (location),
		.failures     (failures),
		.outstanding  (outstanding)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_item(input logic f, input logic [SLOT_W-1:0] slot,
	                         input coord_t x, input coord_t y);
		int g;
		g = steady ? 0 : pick_gap();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		vertex_index <= slot;
		point_x <= x;
		point_y <= y;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	task automatic store_vertex(input int slot, input coord_t x, input coord_t y);
		send_item(FUNC_WRITE, SLOT_W'(slot), x, y);
		poly_x[slot] = x;
		poly_y[slot] = y;
	endtask

	task automatic query(input coord_t x, input coord_t y);
		send_item(FUNC_QUERY, SLOT_W'($urandom), x, y);
	endtask

	// let the checker count the last transfer before polling outstanding
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_count(input int n);
		drain();
		cfg_we <= 1'b1;
		cfg_data <= CNT_W'(n);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic coord_t make_coord(input int mode, input int scale, input int offs);
		int r;
		if (mode == 0)
			return coord_t'((int'($urandom_range(0, 60)) - 30) * scale + offs);
		r = $urandom_range(0, 7);
		if (r == 0)
			return COORD_MIN;
		if (r == 1)
			return COORD_MAX;
		return coord_t'($urandom);
	endfunction

	function automatic void pick_query(output coord_t qx, output coord_t qy);
		int     kind, i, j;
		longint ax, ay, dx, dy, a, b, t, k, lo_x, hi_x, lo_y, hi_y;
		if (poly_m == 0) begin
			qx = coord_t'($urandom);
			qy = coord_t'($urandom);
			return;
		end
		kind = $urandom_range(0, 9);
		i = $urandom_range(0, poly_m - 1);
		j = (i + 1 == poly_m) ? 0 : i + 1;
		ax = poly_x[i];
		ay = poly_y[i];
		dx = longint'(poly_x[j]) - ax;
		dy = longint'(poly_y[j]) - ay;
		lo_x = ax;
		hi_x = ax;
		lo_y = ay;
		hi_y = ay;
		for (int v = 0; v < poly_m; v++) begin
			if (poly_x[v] < lo_x) lo_x = poly_x[v];
			if (poly_x[v] > hi_x) hi_x = poly_x[v];
			if (poly_y[v] < lo_y) lo_y = poly_y[v];
			if (poly_y[v] > hi_y) hi_y = poly_y[v];
		end
		lo_x = (lo_x - 3 < COORD_MIN) ? COORD_MIN : lo_x - 3;
		lo_y = (lo_y - 3 < COORD_MIN) ? COORD_MIN : lo_y - 3;
		hi_x = (hi_x + 3 > COORD_MAX) ? COORD_MAX : hi_x + 3;
		hi_y = (hi_y + 3 > COORD_MAX) ? COORD_MAX : hi_y + 3;
		qx = coord_t'(lo_x + longint'($urandom) % (hi_x - lo_x + 1));
		qy = coord_t'(lo_y + longint'($urandom) % (hi_y - lo_y + 1));
		case (kind)
			0, 1, 2: begin
				// lattice point on edge i
				a = (dx < 0) ? -dx : dx;
				b = (dy < 0) ? -dy : dy;
				while (b != 0) begin
					t = a % b;
					a = b;
					b = t;
				end
				if (a == 0) begin
					qx = coord_t'(ax);
					qy = coord_t'(ay);
				end else begin
					k = longint'($urandom) % (a + 1);
					qx = coord_t'(ax + k * (dx / a));
					qy = coord_t'(ay + k * (dy / a));
				end
			end
			3: begin
				qx = coord_t'(ax);
				qy = coord_t'(ay);
			end
			4: qy = coord_t'(ay);
			5: begin
				qx = coord_t'($urandom);
				qy = coord_t'($urandom);
			end
			default: ;
		endcase
	endfunction

	// result side: random ready gaps, one long hold on request
	initial begin
		int g;
		bit held;
		held = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (!stall_sink)
				held = 1'b0;
			if (stall_sink && !held) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (400) @(posedge clk);
			end else begin
				g = steady ? 0 : pick_gap();
				if (g > 0) begin
					out_ready <= 1'b0;
					repeat (g) @(posedge clk);
				end
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	end

	initial begin
		coord_t cx, cy;
		int     n, m, r, mode, scale, offs;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no polygon yet
		query(COORD_MIN, COORD_MAX);
		query(COORD_MAX, COORD_MIN);

		// full-range square
		store_vertex(0, COORD_MIN, COORD_MIN);
		store_vertex(1, COORD_MAX, COORD_MIN);
		store_vertex(2, COORD_MAX, COORD_MAX);
		store_vertex(3, COORD_MIN, COORD_MAX);
		set_count(1);
		query(0, 0);
		set_count(2);
		query(0, 0);
		set_count(4);
		poly_m = 4;
		query(0, 0);
		query(-5, 12345);
		query(COORD_MIN, 0);
		query(0, COORD_MAX);
		query(COORD_MAX, COORD_MAX);
		query(COORD_MIN, COORD_MIN);

		// triangle with apex on the top row
		store_vertex(2, 0, COORD_MAX);
		set_count(3);
		poly_m = 3;
		query(0, 0);
		query(COORD_MIN, 0);
		query(0, COORD_MIN);
		query(-1, COORD_MAX);
		query(COORD_MAX, COORD_MAX);

		for (int phase = 0; items_sent < ITEM_TARGET; phase++) begin
			case (phase)
				0: n = 127;
				1: n = 64;
				2: n = 3;
				default: begin
					r = $urandom_range(0, 19);
					if (r < 12)
						n = $urandom_range(3, 10);
					else if (r < 14)
						n = $urandom_range(0, 2);
					else if (r < 16)
						n = $urandom_range(11, 63);
					else if (r < 18)
						n = $urandom_range(65, 126);
					else
						n = 64;
				end
			endcase
			m = (n > MAX_VERTICES) ? MAX_VERTICES : n;
			mode = ($urandom_range(0, 4) == 0) ? 1 : 0;
			scale = $urandom_range(0, 1) ? $urandom_range(1, 3) : (1 << $urandom_range(10, 24));
			offs = int'($urandom_range(0, 1 << 29)) - (1 << 28);
			steady = (phase % 4 == 1);
			for (int slot = 0; slot < m; slot++)
				store_vertex(slot, make_coord(mode, scale, offs), make_coord(mode, scale, offs));
			poly_m = m;
			set_count(n);
			if (phase == 2) begin
				// back-to-back queries against a held output
				steady = 1'b1;
				stall_sink = 1'b1;
				repeat (220) begin
					pick_query(cx, cy);
					query(cx, cy);
				end
				stall_sink = 1'b0;
				steady = 1'b0;
			end else begin
				repeat ($urandom_range(30, 70)) begin
					if ($urandom_range(0, 19) == 0) begin
						r = $urandom_range(0, MAX_VERTICES - 1);
						store_vertex(r, make_coord(mode, scale, offs),
							make_coord(mode, scale, offs));
					end else begin
						pick_query(cx, cy);
						query(cx, cy);
					end
				end
			end
		end

		drain();
		if (failures == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
